[design/pbfr_pkg.sv]
`default_nettype none
package pbfr_pkg;

    localparam int NUM_TERMS = 35;
    localparam int MAX_DIM   = 512;

    localparam int DIM_W     = 10;
    localparam int ND_W      = $clog2(MAX_DIM + 1);
    localparam int TAB_AW    = (NUM_TERMS > 1) ? $clog2(NUM_TERMS) : 1;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_DIM_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIM_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIM_Z = 2'd2;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_VOXEL = 1'b1;

    localparam logic [DIM_W-1:0] DIM_RESET = 10'd256;

    // long division: one 28-bit word, four quotient bits per stage
    localparam int WORD_W   = 28;
    localparam int DIV_BITS = 4;
    localparam int DIV_PER  = WORD_W / DIV_BITS;
    localparam int DIV_ST   = 4 * DIV_PER;

    localparam int CQ        = 15;
    localparam int TAYLOR_N  = 12;
    localparam int NGRP      = 6;
    localparam int GRP       = 6;

    localparam logic signed [31:0] L2E     = 32'sd1549082005;
    localparam logic [29:0]        LN2     = 30'd744261118;
    localparam logic [19:0]        OUT_MAX = 20'hFFFFF;
    localparam logic signed [39:0] Y_MIN   = -40'sd268435456;
    localparam logic signed [39:0] Y_MAX   = 40'sd201326592;

    // floor(2^32 / k)
    localparam logic [32:0] RECIP [1:TAYLOR_N] = '{
        33'd4294967296, 33'd2147483648, 33'd1431655765, 33'd1073741824,
        33'd858993459,  33'd715827882,  33'd613566756,  33'd536870912,
        33'd477218588,  33'd429496729,  33'd390451572,  33'd357913941
    };

    // second-order products: xx yy zz xy xz yz
    localparam int SQ_A [0:5] = '{0, 1, 2, 0, 0, 1};
    localparam int SQ_B [0:5] = '{0, 1, 2, 1, 2, 2};
    // terms 4..9 as second-order products
    localparam int D2_MAP [0:5] = '{3, 4, 5, 0, 1, 2};
    // terms 10..19: product times coordinate
    localparam int D3_SQ [0:9] = '{3, 0, 0, 1, 1, 2, 2, 0, 1, 2};
    localparam int D3_C  [0:9] = '{2, 1, 2, 0, 2, 0, 1, 0, 1, 2};
    // terms 20..34: product times product
    localparam int D4_A [0:14] = '{0, 1, 2, 0, 0, 1, 0, 0, 1, 1, 2, 2, 0, 1, 2};
    localparam int D4_B [0:14] = '{5, 4, 3, 1, 2, 2, 3, 4, 3, 5, 4, 5, 0, 1, 2};

    typedef struct packed {
        logic                opcode;
        logic [5:0]          coef_slot;
        logic signed [31:0]  coef_value;
        logic [26:0]         voxel_index;
        logic [15:0]         intensity;
    } item_t;

    typedef struct packed {
        logic [19:0] corrected;
        logic        clipped;
    } result_t;

    typedef struct packed {
        logic [WORD_W-1:0] w;
        logic [ND_W-1:0]   rem;
    } div_t;

    typedef struct packed {
        item_t           it;
        div_t [2:0]      dv;
        logic [ND_W-1:0] xr;
        logic [ND_W-1:0] yr;
    } dstg_t;

    typedef struct packed {
        logic [15:0]       inten;
        logic signed [6:0] n;
        logic [29:0]       u;
        logic [31:0]       e;
    } tctl_t;

    typedef struct packed {
        tctl_t       c;
        logic [30:0] term;
    } tcstg_t;

    typedef struct packed {
        tctl_t       c;
        logic [60:0] mul;
    } tastg_t;

    typedef struct packed {
        tctl_t       c;
        logic [30:0] p;
        logic [63:0] pm;
    } tbstg_t;

    function automatic div_t div_step4(div_t a, logic [ND_W-1:0] d);
        div_t       r;
        logic [ND_W:0] t;
        r = a;
        for (int i = 0; i < DIV_BITS; i++)
        begin
            t   = {r.rem, r.w[WORD_W-1]};
            r.w = {r.w[WORD_W-2:0], 1'b0};
            if (t >= {1'b0, d})
            begin
                t      = t - {1'b0, d};
                r.w[0] = 1'b1;
            end
            r.rem = t[ND_W-1:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

[design/poly_bias_field_removal_unit.sv]
`default_nettype none
// Polynomial bias field correction, one voxel per transfer. Load items write a Q8.24
// coefficient into the term table; voxel items return intensity * exp(-field) as
// Q16.4 with a saturation flag. Throughput is one item per clock; pipeline depth is set
// by the 28 long-division stages that split and centre the index and the 36 stages of
// the twelve-term exponential series. The whole pipeline holds while a result is stalled.
// The user must write dimensions on the cfg channel only while idle; the block does not
// enforce this. The term table must be loaded before voxels that use it.
module poly_bias_field_removal_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              voxel_valid,
    output logic                              voxel_stall,
    input  pbfr_pkg::item_t                   voxel_data,
    output logic                              result_valid,
    input  logic                              result_stall,
    output pbfr_pkg::result_t                 result_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [pbfr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pbfr_pkg::DIM_W-1:0]        cfg_data
);
    import pbfr_pkg::*;

    logic                adv;
    logic [DIM_W-1:0]    dim_reg [0:2];
    logic [ND_W-1:0]     dim_e   [0:2];

    assign cfg_ready   = 1'b1;
    assign adv         = !(result_valid && result_stall);
    assign voxel_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_reg[0] <= DIM_RESET;
            dim_reg[1] <= DIM_RESET;
            dim_reg[2] <= DIM_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_DIM_X: dim_reg[0] <= cfg_data;
                CFG_DIM_Y: dim_reg[1] <= cfg_data;
                CFG_DIM_Z: dim_reg[2] <= cfg_data;
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            if (dim_reg[l] == '0)
                dim_e[l] = ND_W'(1);
            else if (32'(dim_reg[l]) > MAX_DIM)
                dim_e[l] = ND_W'(MAX_DIM);
            else
                dim_e[l] = ND_W'(dim_reg[l]);
        end
    end

    // ---- index split and centring ----
    dstg_t           dp_src  [0:DIV_ST];
    dstg_t           dp_next [0:DIV_ST-1];
    dstg_t           dp_reg  [0:DIV_ST-1];
    logic [DIV_ST:0] dvs_src;
    logic [DIV_ST-1:0] dv_reg;

    always_comb
    begin
        dp_src[0]          = '0;
        dp_src[0].it       = voxel_data;
        dp_src[0].dv[0].w  = WORD_W'(voxel_data.voxel_index);
    end
    assign dvs_src[0] = voxel_valid;

    for (genvar s = 0; s < DIV_ST; s++)
    begin : g_div
        localparam int PH = s / DIV_PER;

        assign dp_src[s+1]  = dp_reg[s];
        assign dvs_src[s+1] = dv_reg[s];

        always_comb
        begin
            dstg_t           b;
            logic [ND_W-1:0] zr;
            b  = dp_src[s];
            zr = b.dv[0].rem;
            if ((s % DIV_PER) == 0)
            begin
                if (PH == 1)
                begin
                    b.xr        = zr;
                    b.dv[0].rem = '0;
                end
                else if (PH == 2)
                begin
                    b.yr        = zr;
                    b.dv[0].rem = '0;
                end
                else if (PH == 3)
                begin
                    b.dv[0].w   = WORD_W'(b.xr) << CQ;
                    b.dv[1].w   = WORD_W'(b.yr) << CQ;
                    b.dv[2].w   = WORD_W'(zr) << CQ;
                    b.dv[0].rem = '0;
                    b.dv[1].rem = '0;
                    b.dv[2].rem = '0;
                end
            end
            if (PH < 3)
                b.dv[0] = div_step4(b.dv[0], dim_e[PH % 3]);
            else
            begin
                for (int l = 0; l < 3; l++)
                    b.dv[l] = div_step4(b.dv[l], dim_e[l]);
            end
            dp_next[s] = b;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_reg[s] <= 1'b0;
            else if (adv)
                dv_reg[s] <= dvs_src[s];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
                dp_reg[s] <= dp_next[s];
        end
    end

    // ---- monomials ----
    logic               v0_reg, v1_reg, v2_reg, v3_reg;
    item_t              it0_reg, it1_reg, it2_reg, it3_reg;
    logic signed [15:0] c0_next [0:2];
    logic signed [15:0] c0_reg  [0:2];
    logic signed [15:0] c1_reg  [0:2];
    logic signed [15:0] c2_reg  [0:2];
    logic signed [29:0] sq1_next [0:5];
    logic signed [29:0] sq1_reg  [0:5];
    logic signed [29:0] sq2_reg  [0:5];
    logic signed [45:0] p3_next [0:9];
    logic signed [45:0] p3_reg  [0:9];
    logic signed [59:0] p4_next [0:14];
    logic signed [59:0] p4_reg  [0:14];
    logic signed [30:0] mono_next [1:34];
    logic signed [30:0] mono_reg  [1:34];

    always_comb
    begin
        for (int l = 0; l < 3; l++)
            c0_next[l] = $signed({1'b0, dp_reg[DIV_ST-1].dv[l].w[14:0]}) - 16'sd16384;
        for (int i = 0; i < 6; i++)
            sq1_next[i] = 30'(c0_reg[SQ_A[i]]) * 30'(c0_reg[SQ_B[i]]);
        for (int i = 0; i < 10; i++)
            p3_next[i] = 46'(sq1_reg[D3_SQ[i]]) * 46'(c1_reg[D3_C[i]]);
        for (int i = 0; i < 15; i++)
            p4_next[i] = 60'(sq1_reg[D4_A[i]]) * 60'(sq1_reg[D4_B[i]]);
        for (int j = 1; j <= 3; j++)
            mono_next[j] = 31'(c2_reg[j-1]) <<< CQ;
        for (int j = 4; j <= 9; j++)
            mono_next[j] = 31'(sq2_reg[D2_MAP[j-4]]);
        for (int j = 10; j <= 19; j++)
            mono_next[j] = 31'((p3_reg[j-10] + 46'sd16384) >>> 15);
        for (int j = 20; j <= 34; j++)
            mono_next[j] = 31'((p4_reg[j-20] + 60'sd536870912) >>> 30);
    end

    // ---- coefficient table and term products ----
    logic signed [31:0] coef_table [0:NUM_TERMS-1];
    logic               v4_reg;
    logic [15:0]        in4_reg;
    logic signed [62:0] prod4_next [1:34];
    logic signed [62:0] prod4_reg  [1:34];

    always_comb
    begin
        for (int j = 1; j <= 34; j++)
        begin
            if (j < NUM_TERMS)
                prod4_next[j] = 63'(coef_table[j % NUM_TERMS]) * 63'(mono_reg[j]);
            else
                prod4_next[j] = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && v3_reg && (it3_reg.opcode == OP_LOAD)
            && (32'(it3_reg.coef_slot) < NUM_TERMS))
            coef_table[it3_reg.coef_slot[TAB_AW-1:0]] <= it3_reg.coef_value;
    end

    // ---- field sum and exponent argument ----
    logic               v5_reg, v6_reg, v7_reg, v8_reg, v9_reg, v10_reg;
    logic [15:0]        in5_reg, in6_reg, in7_reg, in8_reg, in9_reg, in10_reg;
    logic signed [32:0] tr [1:34];
    logic signed [38:0] grp5_next [0:NGRP-1];
    logic signed [38:0] grp5_reg  [0:NGRP-1];
    logic signed [38:0] f_sum;
    logic signed [39:0] y_wide;
    logic signed [28:0] y6_next, y6_reg;
    logic signed [59:0] yl7_reg;
    logic signed [29:0] t_q;
    logic signed [6:0]  n8_reg, n9_reg, n10_reg;
    logic [23:0]        r8_reg;
    logic [53:0]        rl9_reg;
    logic [29:0]        u10_reg;

    always_comb
    begin
        for (int j = 1; j <= 34; j++)
            tr[j] = 33'((prod4_reg[j] + 63'sd536870912) >>> 30);
        for (int g = 0; g < NGRP; g++)
        begin
            grp5_next[g] = '0;
            for (int m = 0; m < GRP; m++)
            begin
                if (g * GRP + m + 1 <= 34)
                    grp5_next[g] = grp5_next[g] + 39'(tr[g * GRP + m + 1]);
            end
        end
        f_sum = '0;
        for (int g = 0; g < NGRP; g++)
            f_sum = f_sum + grp5_reg[g];
        y_wide = -40'(f_sum);
        if (y_wide < Y_MIN)
            y_wide = Y_MIN;
        else if (y_wide > Y_MAX)
            y_wide = Y_MAX;
        y6_next = 29'(y_wide);
        t_q     = 30'((yl7_reg + 60'sd536870912) >>> 30);
    end

    // ---- e^u series ----
    tcstg_t tc_src [0:TAYLOR_N];
    tastg_t ta_reg [1:TAYLOR_N];
    tbstg_t tb_reg [1:TAYLOR_N];
    tcstg_t tc_reg [1:TAYLOR_N];
    logic [TAYLOR_N:0] tcv_src;
    logic [TAYLOR_N:1] tav_reg, tbv_reg, tcv_reg;

    always_comb
    begin
        tc_src[0].c.inten = in10_reg;
        tc_src[0].c.n     = n10_reg;
        tc_src[0].c.u     = u10_reg;
        tc_src[0].c.e     = 32'd1073741824;
        tc_src[0].term    = 31'd1073741824;
    end
    assign tcv_src[0] = v10_reg;

    for (genvar k = 1; k <= TAYLOR_N; k++)
    begin : g_tay
        tastg_t      ta_next;
        tbstg_t      tb_next;
        tcstg_t      tc_next;
        logic [30:0] qe;
        logic [34:0] rm;

        assign tc_src[k]  = tc_reg[k];
        assign tcv_src[k] = tcv_reg[k];

        always_comb
        begin
            ta_next.c   = tc_src[k-1].c;
            ta_next.mul = 61'(tc_src[k-1].term) * 61'(tc_src[k-1].c.u);
            tb_next.c   = ta_reg[k].c;
            tb_next.p   = 31'((ta_reg[k].mul + 61'd536870912) >> 30);
            tb_next.pm  = 64'(tb_next.p) * 64'(RECIP[k]);
            qe          = tb_reg[k].pm[62:32];
            rm          = 35'(tb_reg[k].p) - 35'(qe) * 35'(k);
            tc_next.c   = tb_reg[k].c;
            tc_next.term = (rm >= 35'(k)) ? qe + 31'd1 : qe;
            tc_next.c.e  = tb_reg[k].c.e + 32'(tc_next.term);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                tav_reg[k] <= 1'b0;
                tbv_reg[k] <= 1'b0;
                tcv_reg[k] <= 1'b0;
            end
            else if (adv)
            begin
                tav_reg[k] <= tcv_src[k-1];
                tbv_reg[k] <= tav_reg[k];
                tcv_reg[k] <= tbv_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                ta_reg[k] <= ta_next;
                tb_reg[k] <= tb_next;
                tc_reg[k] <= tc_next;
            end
        end
    end

    // ---- scaling and saturation ----
    logic              vx_reg, rv_reg;
    logic [47:0]       px_reg;
    logic [5:0]        shx_reg;
    logic              zx_reg;
    logic signed [7:0] sh_s;
    logic [48:0]       rnd;
    logic [48:0]       val;
    result_t           res_next, res_reg;

    always_comb
    begin
        sh_s = 8'sd26 - 8'(tc_reg[TAYLOR_N].c.n);
        rnd  = 49'd1 << (shx_reg - 6'd1);
        val  = (49'(px_reg) + rnd) >> shx_reg;
        if (zx_reg)
            res_next = '0;
        else if (val > 49'(OUT_MAX))
        begin
            res_next.corrected = OUT_MAX;
            res_next.clipped   = 1'b1;
        end
        else
        begin
            res_next.corrected = val[19:0];
            res_next.clipped   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg  <= 1'b0;
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            v4_reg  <= 1'b0;
            v5_reg  <= 1'b0;
            v6_reg  <= 1'b0;
            v7_reg  <= 1'b0;
            v8_reg  <= 1'b0;
            v9_reg  <= 1'b0;
            v10_reg <= 1'b0;
            vx_reg  <= 1'b0;
            rv_reg  <= 1'b0;
        end
        else if (adv)
        begin
            v0_reg  <= dv_reg[DIV_ST-1];
            v1_reg  <= v0_reg;
            v2_reg  <= v1_reg;
            v3_reg  <= v2_reg;
            v4_reg  <= v3_reg && (it3_reg.opcode == OP_VOXEL);
            v5_reg  <= v4_reg;
            v6_reg  <= v5_reg;
            v7_reg  <= v6_reg;
            v8_reg  <= v7_reg;
            v9_reg  <= v8_reg;
            v10_reg <= v9_reg;
            vx_reg  <= tcv_reg[TAYLOR_N];
            rv_reg  <= vx_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            it0_reg   <= dp_reg[DIV_ST-1].it;
            c0_reg    <= c0_next;
            it1_reg   <= it0_reg;
            c1_reg    <= c0_reg;
            sq1_reg   <= sq1_next;
            it2_reg   <= it1_reg;
            c2_reg    <= c1_reg;
            sq2_reg   <= sq1_reg;
            p3_reg    <= p3_next;
            p4_reg    <= p4_next;
            it3_reg   <= it2_reg;
            mono_reg  <= mono_next;
            in4_reg   <= it3_reg.intensity;
            prod4_reg <= prod4_next;
            in5_reg   <= in4_reg;
            grp5_reg  <= grp5_next;
            in6_reg   <= in5_reg;
            y6_reg    <= y6_next;
            in7_reg   <= in6_reg;
            yl7_reg   <= 60'(y6_reg) * 60'(L2E);
            in8_reg   <= in7_reg;
            n8_reg    <= 7'(t_q >>> 24);
            r8_reg    <= t_q[23:0];
            in9_reg   <= in8_reg;
            n9_reg    <= n8_reg;
            rl9_reg   <= 54'(r8_reg) * 54'(LN2);
            in10_reg  <= in9_reg;
            n10_reg   <= n9_reg;
            u10_reg   <= 30'((rl9_reg + 54'd8388608) >> 24);
            px_reg    <= 48'(tc_reg[TAYLOR_N].c.inten) * 48'(tc_reg[TAYLOR_N].c.e);
            shx_reg   <= sh_s[5:0];
            zx_reg    <= (tc_reg[TAYLOR_N].c.inten == '0);
            res_reg   <= res_next;
        end
    end

    assign result_valid = rv_reg;
    assign result_data  = res_reg;

`ifndef SYNTHESIS
    a_clip_max: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_data.clipped) |-> (result_data.corrected == OUT_MAX))
        else $error("clipped result below full scale");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=> ($stable(v6_reg) && $stable(y6_reg)))
        else $error("pipeline moved during stall");

    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && vx_reg && zx_reg) |=> (result_data.corrected == '0 && !result_data.clipped))
        else $error("zero intensity gave nonzero result");
`endif

endmodule
`default_nettype wire
